// ===== src/emav_pkg.sv =====
package emav_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;

    localparam int CTR_W      = COORD_BITS + 1;
    localparam int QV_W       = COORD_BITS + 2;
    localparam int HALF_W     = 16;
    localparam int BIN_W      = 12;
    localparam int IMG_W      = 16;
    localparam int WID_W      = IMG_W - 1;
    localparam int BW_W       = BIN_W + WID_W;
    localparam int LEN_W      = 2 * COORD_BITS + 1;
    localparam int MAG_W      = 2 * COORD_BITS + 2;
    localparam int DOT_W      = 2 * COORD_BITS + 4;
    localparam int NUM_W      = 2 * MAG_W + LEN_W;
    localparam int DEN_W      = 2 * LEN_W + 3;
    localparam int ROOT_W     = (NUM_W + 1) / 2;
    localparam int ALPHA_SH   = (FRAC_BITS >= 1) ? 2 * FRAC_BITS - 2 : 0;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 1'd1;

    localparam logic [IMG_W-1:0] IMG_RST = 16'd512;
    localparam logic [BIN_W-1:0] BIN_RST = 12'd64;

    typedef enum logic [1:0] {
        ST_VALID,
        ST_DEGEN,
        ST_SAT,
        ST_ZERO_W
    } t_status;

    typedef struct packed {
        logic [COORD_BITS-1:0] end_a_x;
        logic [COORD_BITS-1:0] end_a_y;
        logic [COORD_BITS-1:0] end_b_x;
        logic [COORD_BITS-1:0] end_b_y;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_item;

    typedef struct packed {
        logic [CTR_W-1:0]  center_x_twice;
        logic [CTR_W-1:0]  center_y_twice;
        logic [HALF_W-1:0] half_major_axis;
        logic [BIN_W-1:0]  minor_bin;
        t_status           vote_status;
    } t_result;

endpackage

// ===== src/emav_div_cell.sv =====
module emav_div_cell #(
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_dq,
    input  logic [DW-1:0] i_den,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_dq,
    output logic [DW-1:0] o_den
);

    logic [DW:0]   n_cur;
    logic [DW:0]   n_diff;
    logic          n_ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_dq;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_dq;
    logic [DW-1:0] r_den;

    always_comb begin
        n_cur  = {i_rem, i_dq[QW-1]};
        n_diff = n_cur - {1'b0, i_den};
        n_ge   = n_cur >= {1'b0, i_den};
        n_rem  = n_ge ? n_diff[DW-1:0] : n_cur[DW-1:0];
        if (QW > 1) begin
            n_dq = {i_dq[QW-2:0], n_ge};
        end else begin
            n_dq = QW'(n_ge);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_dq  = r_dq;
    assign o_den = r_den;

endmodule

// ===== src/emav_sqrt_cell.sv =====
module emav_sqrt_cell #(
    parameter int RW = 8
) (
    input  logic            i_clk,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [2*RW-1:0] i_x,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_x
);

    logic [RW+3:0]   n_cur;
    logic [RW+3:0]   n_trial;
    logic [RW+3:0]   n_diff;
    logic            n_ge;
    logic [RW+1:0]   n_rem;
    logic [RW-1:0]   n_root;
    logic [2*RW-1:0] n_x;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [2*RW-1:0] r_x;

    always_comb begin
        n_cur   = {i_rem, i_x[2*RW-1 -: 2]};
        n_trial = (RW+4)'({i_root, 2'b01});
        n_diff  = n_cur - n_trial;
        n_ge    = n_cur >= n_trial;
        n_rem   = n_ge ? n_diff[RW+1:0] : n_cur[RW+1:0];
        n_root  = {i_root[RW-2:0], n_ge};
        n_x     = {i_x[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_x    <= n_x;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_x    = r_x;

endmodule

// ===== src/ellipse_minor_axis_vote_core.sv =====
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+--------------------------
// item      | in        | start, busy                | i_item (emav_pkg::t_item)
// result    | out       | o_strobe                   | o_result (t_result)
// config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One word accepted per cycle; busy and o_cfg_ready stay constant.
// Pipeline depth is set by the restoring divide chain for beta^2, the square root chain and
// the bin divide chain.
// Synchronous active-low reset clears the pipeline valids and loads register defaults.
// A config write recomputes the bin width with a serial divide, well inside the pipeline depth.
// Results cannot be stalled.
module ellipse_minor_axis_vote_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  emav_pkg::t_item                      i_item,
    output logic                                 o_strobe,
    output emav_pkg::t_result                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [emav_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [emav_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CB     = emav_pkg::COORD_BITS;
    localparam int CTR_W  = emav_pkg::CTR_W;
    localparam int QV_W   = emav_pkg::QV_W;
    localparam int LEN_W  = emav_pkg::LEN_W;
    localparam int MAG_W  = emav_pkg::MAG_W;
    localparam int DOT_W  = emav_pkg::DOT_W;
    localparam int NUM_W  = emav_pkg::NUM_W;
    localparam int DEN_W  = emav_pkg::DEN_W;
    localparam int RW     = emav_pkg::ROOT_W;
    localparam int BIN_W  = emav_pkg::BIN_W;
    localparam int IMG_W  = emav_pkg::IMG_W;
    localparam int WID_W  = emav_pkg::WID_W;
    localparam int BW_W   = emav_pkg::BW_W;
    localparam int HALF_W = emav_pkg::HALF_W;
    localparam int LAT    = 8 + NUM_W + RW + BIN_W;
    localparam int CNT_W  = $clog2(WID_W + 1);

    typedef struct packed {
        logic [CTR_W-1:0] sx;
        logic [CTR_W-1:0] sy;
    } t_ctr;

    typedef struct packed {
        t_ctr             ctr;
        logic [LEN_W-1:0] l2;
        logic             degen;
        logic             pos;
    } t_qside;

    typedef struct packed {
        t_ctr ctr;
        logic degen;
        logic pos;
    } t_sside;

    typedef struct packed {
        t_ctr              ctr;
        logic [HALF_W-1:0] alpha;
        emav_pkg::t_status status;
        logic [BIN_W-1:0]  bin_fix;
        logic              use_q;
    } t_bside;

    // configuration and bin width
    logic [IMG_W-1:0] r_image_size;
    logic [BIN_W-1:0] r_bin_count;
    logic             r_cload;
    logic [CNT_W-1:0] r_ccnt;
    logic [BIN_W-1:0] r_crem;
    logic [WID_W-1:0] r_cdq;
    logic [WID_W-1:0] r_width;
    logic [BW_W-1:0]  r_bw;
    logic             n_cfg_we;
    logic [BIN_W:0]   n_ccur;
    logic [BIN_W:0]   n_cdiff;
    logic             n_cge;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign n_cfg_we    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= emav_pkg::IMG_RST;
            r_bin_count  <= emav_pkg::BIN_RST;
            r_cload      <= 1'b1;
            r_ccnt       <= '0;
        end else begin
            if (n_cfg_we) begin
                unique case (i_cfg_index)
                    emav_pkg::CFG_IMAGE_SIZE: r_image_size <= i_cfg_data[IMG_W-1:0];
                    emav_pkg::CFG_BIN_COUNT:  r_bin_count  <= i_cfg_data[BIN_W-1:0];
                    default: ;
                endcase
                r_cload <= 1'b1;
            end else if (r_cload) begin
                r_cload <= 1'b0;
                r_ccnt  <= CNT_W'(WID_W);
            end else if (r_ccnt != '0) begin
                r_ccnt <= r_ccnt - 1'b1;
            end
        end
    end

    always_comb begin
        n_ccur  = {r_crem, r_cdq[WID_W-1]};
        n_cdiff = n_ccur - {1'b0, r_bin_count};
        n_cge   = n_ccur >= {1'b0, r_bin_count};
    end

    always_ff @(posedge i_clk) begin
        if (r_cload) begin
            r_crem <= '0;
            r_cdq  <= r_image_size[IMG_W-1:1];
        end else if (r_ccnt != '0) begin
            r_crem <= n_cge ? n_cdiff[BIN_W-1:0] : n_ccur[BIN_W-1:0];
            r_cdq  <= {r_cdq[WID_W-2:0], n_cge};
        end
        r_width <= (r_bin_count == '0) ? '0 : r_cdq;
        r_bw    <= r_width * r_bin_count;
    end

    // valid line
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_strobe = r_vld[LAT-1];

    // front end: vectors, products, dot and cross, magnitudes
    t_ctr                     n_a_ctr;
    logic signed [CTR_W-1:0]  n_a_vx, n_a_vy;
    logic signed [QV_W-1:0]   n_a_qx, n_a_qy;
    t_ctr                     r_a_ctr, r_b_ctr, r_c_ctr, r_d_ctr, r_e_ctr, r_f_ctr;
    logic signed [CTR_W-1:0]  r_a_vx, r_a_vy;
    logic signed [QV_W-1:0]   r_a_qx, r_a_qy;
    logic signed [2*CB+1:0]   r_b_vxx, r_b_vyy;
    logic signed [2*CB+2:0]   r_b_qxvx, r_b_qyvy, r_b_qxvy, r_b_qyvx;
    logic [LEN_W-1:0]         r_c_l2, r_d_l2, r_e_l2, r_f_l2;
    logic signed [DOT_W-1:0]  r_c_dot, r_c_crs;
    logic signed [DOT_W-1:0]  n_d_ndot, n_d_ncrs;
    logic [MAG_W-1:0]         r_d_adot, r_d_ac;
    logic [2*MAG_W-1:0]       r_e_acsq;
    logic [LEN_W-1:0]         r_e_dm;
    logic [LEN_W:0]           r_e_dp;
    logic                     r_e_degen, r_e_pos, r_f_degen, r_f_pos;
    logic [2*LEN_W:0]         n_f_dprod;
    logic [MAG_W+LEN_W-1:0]   r_f_lo, r_f_hi;
    logic [DEN_W-1:0]         r_f_den, r_g_den;
    logic [NUM_W-1:0]         r_g_num;
    t_qside                   r_g_side;

    always_comb begin
        n_a_ctr.sx = {1'b0, i_item.end_a_x} + {1'b0, i_item.end_b_x};
        n_a_ctr.sy = {1'b0, i_item.end_a_y} + {1'b0, i_item.end_b_y};
        n_a_vx     = $signed({1'b0, i_item.end_b_x}) - $signed({1'b0, i_item.end_a_x});
        n_a_vy     = $signed({1'b0, i_item.end_b_y}) - $signed({1'b0, i_item.end_a_y});
        n_a_qx     = $signed({1'b0, i_item.point_x, 1'b0}) - $signed({1'b0, n_a_ctr.sx});
        n_a_qy     = $signed({1'b0, i_item.point_y, 1'b0}) - $signed({1'b0, n_a_ctr.sy});
        n_d_ndot   = -r_c_dot;
        n_d_ncrs   = -r_c_crs;
        n_f_dprod  = r_e_dm * r_e_dp;
    end

    always_ff @(posedge i_clk) begin
        r_a_ctr  <= n_a_ctr;
        r_a_vx   <= n_a_vx;
        r_a_vy   <= n_a_vy;
        r_a_qx   <= n_a_qx;
        r_a_qy   <= n_a_qy;

        r_b_ctr  <= r_a_ctr;
        r_b_vxx  <= r_a_vx * r_a_vx;
        r_b_vyy  <= r_a_vy * r_a_vy;
        r_b_qxvx <= r_a_qx * r_a_vx;
        r_b_qyvy <= r_a_qy * r_a_vy;
        r_b_qxvy <= r_a_qx * r_a_vy;
        r_b_qyvx <= r_a_qy * r_a_vx;

        r_c_ctr  <= r_b_ctr;
        r_c_l2   <= r_b_vxx[LEN_W-1:0] + r_b_vyy[LEN_W-1:0];
        r_c_dot  <= DOT_W'(r_b_qxvx) + DOT_W'(r_b_qyvy);
        r_c_crs  <= DOT_W'(r_b_qxvy) - DOT_W'(r_b_qyvx);

        r_d_ctr  <= r_c_ctr;
        r_d_l2   <= r_c_l2;
        r_d_adot <= r_c_dot[DOT_W-1] ? n_d_ndot[MAG_W-1:0] : r_c_dot[MAG_W-1:0];
        r_d_ac   <= r_c_crs[DOT_W-1] ? n_d_ncrs[MAG_W-1:0] : r_c_crs[MAG_W-1:0];

        r_e_ctr   <= r_d_ctr;
        r_e_l2    <= r_d_l2;
        r_e_acsq  <= r_d_ac * r_d_ac;
        r_e_dm    <= r_d_l2 - r_d_adot[LEN_W-1:0];
        r_e_dp    <= {1'b0, r_d_l2} + {1'b0, r_d_adot[LEN_W-1:0]};
        r_e_degen <= (MAG_W'(r_d_l2) == r_d_adot) ||
                     ((MAG_W'(r_d_l2) < r_d_adot) && (r_d_ac != '0));
        r_e_pos   <= MAG_W'(r_d_l2) > r_d_adot;

        r_f_ctr   <= r_e_ctr;
        r_f_l2    <= r_e_l2;
        r_f_degen <= r_e_degen;
        r_f_pos   <= r_e_pos;
        r_f_lo    <= r_e_acsq[MAG_W-1:0] * r_e_l2;
        r_f_hi    <= r_e_acsq[2*MAG_W-1:MAG_W] * r_e_l2;
        r_f_den   <= {n_f_dprod, 2'b00};

        r_g_num        <= (NUM_W'(r_f_hi) << MAG_W) + NUM_W'(r_f_lo);
        r_g_den        <= r_f_den;
        r_g_side.ctr   <= r_f_ctr;
        r_g_side.l2    <= r_f_l2;
        r_g_side.degen <= r_f_degen;
        r_g_side.pos   <= r_f_pos;
    end

    // beta^2 quotient chain
    logic [DEN_W-1:0] w_qrem [0:NUM_W];
    logic [NUM_W-1:0] w_qdq  [0:NUM_W];
    logic [DEN_W-1:0] w_qden [0:NUM_W];
    t_qside           r_qs   [0:NUM_W-1];

    assign w_qrem[0] = '0;
    assign w_qdq[0]  = r_g_num;
    assign w_qden[0] = r_g_den;

    for (genvar i = 0; i < NUM_W; i++) begin : g_qdiv
        emav_div_cell #(
            .DW (DEN_W),
            .QW (NUM_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (w_qrem[i]),
            .i_dq  (w_qdq[i]),
            .i_den (w_qden[i]),
            .o_rem (w_qrem[i+1]),
            .o_dq  (w_qdq[i+1]),
            .o_den (w_qden[i+1])
        );
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_qs[0] <= r_g_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_qs[i] <= r_qs[i-1];
            end
        end
    end

    // square root chains: beta^2 quotient and alpha
    logic [RW+1:0]   w_srem  [0:RW];
    logic [RW-1:0]   w_sroot [0:RW];
    logic [2*RW-1:0] w_sx    [0:RW];
    logic [RW+1:0]   w_arem  [0:RW];
    logic [RW-1:0]   w_aroot [0:RW];
    logic [2*RW-1:0] w_ax    [0:RW];
    t_sside          n_s_side;
    t_sside          r_ss    [0:RW-1];

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_sx[0]    = (2*RW)'(w_qdq[NUM_W]);
    assign w_arem[0]  = '0;
    assign w_aroot[0] = '0;
    assign w_ax[0]    = (2*RW)'(r_qs[NUM_W-1].l2) << emav_pkg::ALPHA_SH;

    always_comb begin
        n_s_side.ctr   = r_qs[NUM_W-1].ctr;
        n_s_side.degen = r_qs[NUM_W-1].degen;
        n_s_side.pos   = r_qs[NUM_W-1].pos;
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        emav_sqrt_cell #(
            .RW (RW)
        ) u_beta (
            .i_clk  (i_clk),
            .i_rem  (w_srem[j]),
            .i_root (w_sroot[j]),
            .i_x    (w_sx[j]),
            .o_rem  (w_srem[j+1]),
            .o_root (w_sroot[j+1]),
            .o_x    (w_sx[j+1])
        );
        emav_sqrt_cell #(
            .RW (RW)
        ) u_alpha (
            .i_clk  (i_clk),
            .i_rem  (w_arem[j]),
            .i_root (w_aroot[j]),
            .i_x    (w_ax[j]),
            .o_rem  (w_arem[j+1]),
            .o_root (w_aroot[j+1]),
            .o_x    (w_ax[j+1])
        );
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_ss[0] <= n_s_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_ss[j] <= r_ss[j-1];
            end
        end
    end

    // vote decision and bin divide chain
    logic [RW-1:0]    n_beta;
    logic [RW-1:0]    n_alpha_r;
    logic             n_wz;
    logic             n_sat;
    t_bside           n_b_side;
    logic [WID_W-1:0] w_brem [0:BIN_W];
    logic [BIN_W-1:0] w_bdq  [0:BIN_W];
    logic [WID_W-1:0] w_bden [0:BIN_W];
    t_bside           r_bs   [0:BIN_W-1];

    always_comb begin
        n_beta    = w_sroot[RW];
        n_alpha_r = (emav_pkg::FRAC_BITS == 0) ? (w_aroot[RW] >> 1) : w_aroot[RW];
        n_wz      = r_width == '0;
        n_sat     = n_beta >= RW'(r_bw);

        n_b_side.ctr   = r_ss[RW-1].ctr;
        n_b_side.alpha = (|n_alpha_r[RW-1:HALF_W]) ? '1 : n_alpha_r[HALF_W-1:0];
        n_b_side.bin_fix = '0;
        n_b_side.use_q   = 1'b0;
        if (r_ss[RW-1].degen) begin
            n_b_side.status = emav_pkg::ST_DEGEN;
        end else if (n_wz) begin
            n_b_side.status = emav_pkg::ST_ZERO_W;
        end else if (r_ss[RW-1].pos && n_sat) begin
            n_b_side.status  = emav_pkg::ST_SAT;
            n_b_side.bin_fix = r_bin_count - 1'b1;
        end else begin
            n_b_side.status = emav_pkg::ST_VALID;
            n_b_side.use_q  = r_ss[RW-1].pos;
        end
    end

    assign w_brem[0] = n_beta[BIN_W+WID_W-1:BIN_W];
    assign w_bdq[0]  = n_beta[BIN_W-1:0];
    assign w_bden[0] = r_width;

    for (genvar m = 0; m < BIN_W; m++) begin : g_bdiv
        emav_div_cell #(
            .DW (WID_W),
            .QW (BIN_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (w_brem[m]),
            .i_dq  (w_bdq[m]),
            .i_den (w_bden[m]),
            .o_rem (w_brem[m+1]),
            .o_dq  (w_bdq[m+1]),
            .o_den (w_bden[m+1])
        );
        if (m == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_bs[0] <= n_b_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_bs[m] <= r_bs[m-1];
            end
        end
    end

    emav_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        r_result.center_x_twice  <= r_bs[BIN_W-1].ctr.sx;
        r_result.center_y_twice  <= r_bs[BIN_W-1].ctr.sy;
        r_result.half_major_axis <= r_bs[BIN_W-1].alpha;
        r_result.minor_bin       <= r_bs[BIN_W-1].use_q ? w_bdq[BIN_W] : r_bs[BIN_W-1].bin_fix;
        r_result.vote_status     <= r_bs[BIN_W-1].status;
    end

    assign o_result = r_result;

endmodule
